/* src/srsc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srsc_pkg: shared types and helpers for the result set classifier
// Holds the scan phase enum, the queue request format, the keyword match
// state and the byte-level match functions used by the back end.
// ----------------------------------------------------------------------------
package srsc_pkg;

    // queue depth between front and back
    localparam int QUEUE_DEPTH = 4;

    // character codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_UP_E  = 8'h45;
    localparam logic [7:0] CH_UP_R  = 8'h52;

    // keyword lengths
    localparam logic [2:0] SELECT_LEN = 3'd6;
    localparam logic [2:0] WITH_LEN   = 3'd4;
    localparam logic [3:0] RET_LEN    = 4'd9;
    localparam logic [2:0] TOK_MAX    = 3'd7;
    // matched length "RETUR" whose border is "R"
    localparam logic [3:0] RET_BORDER_AT = 4'd5;

    // keywords, upper case
    localparam logic [7:0] SELECT_KW [6] = '{8'h53, 8'h45, 8'h4C, 8'h45, 8'h43, 8'h54};
    localparam logic [7:0] WITH_KW [4]   = '{8'h57, 8'h49, 8'h54, 8'h48};
    localparam logic [7:0] RET_KW [9]    = '{8'h52, 8'h45, 8'h54, 8'h55, 8'h52,
                                             8'h4E, 8'h49, 8'h4E, 8'h47};

    // leading skip phases
    typedef enum logic [2:0] {
        PH_BLANK,
        PH_DASH,
        PH_SLASH,
        PH_LINE,
        PH_BLOCK,
        PH_BSTAR,
        PH_TEXT
    } phase_t;

    // one request from front to back
    typedef struct packed {
        logic       is_end;   // end of statement
        logic       in_text;  // statement text had started at the end
        logic       has_pre;  // held '-' or '/' goes first
        logic [7:0] pre_byte;
        logic [7:0] body;
    } req_t;

    // queue status seen by the top level
    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

    // keyword match state
    typedef struct packed {
        logic [2:0] tok_pos;
        logic       sel_alive;
        logic       with_alive;
        logic       kw_hit;
        logic [3:0] ret_prog;
        logic       ret_hit;
    } match_t;

    localparam match_t MATCH_RESET = '{
        tok_pos: 3'd0, sel_alive: 1'b1, with_alive: 1'b1, kw_hit: 1'b0,
        ret_prog: 4'd0, ret_hit: 1'b0
    };

    function automatic logic [7:0] upcase(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h61 && c <= 8'h7A)
        begin
            r = c - 8'h20;
        end
        return r;
    endfunction

    function automatic logic is_boundary(input logic [7:0] c);
        logic word;
        word = (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A)
            || (c >= 8'h30 && c <= 8'h39) || (c == CH_UNDER);
        return !word;
    endfunction

    // next RETURNING progress, with the substring search fallback
    function automatic logic [3:0] ret_next(input logic [3:0] k, input logic [7:0] u);
        logic [3:0] r;
        r = 4'd0;
        if (k < RET_LEN && u == RET_KW[k])
        begin
            r = k + 4'd1;
        end
        else if (k == RET_BORDER_AT && u == CH_UP_E)
        begin
            r = 4'd2;
        end
        else if (u == CH_UP_R)
        begin
            r = 4'd1;
        end
        return r;
    endfunction

    // one nonzero byte of statement text
    function automatic match_t match_step(input match_t s, input logic [7:0] c);
        match_t     r;
        logic [7:0] u;
        logic       bnd;
        r   = s;
        u   = upcase(c);
        bnd = is_boundary(c);
        if (s.tok_pos < SELECT_LEN)
        begin
            r.sel_alive = s.sel_alive && (u == SELECT_KW[s.tok_pos]);
        end
        else if (s.tok_pos == SELECT_LEN)
        begin
            if (s.sel_alive && bnd)
            begin
                r.kw_hit = 1'b1;
            end
            r.sel_alive = 1'b0;
        end
        if (s.tok_pos < WITH_LEN)
        begin
            r.with_alive = s.with_alive && (u == WITH_KW[s.tok_pos[1:0]]);
        end
        else if (s.tok_pos == WITH_LEN)
        begin
            if (s.with_alive && bnd)
            begin
                r.kw_hit = 1'b1;
            end
            r.with_alive = 1'b0;
        end
        if (s.tok_pos < TOK_MAX)
        begin
            r.tok_pos = s.tok_pos + 3'd1;
        end
        if (s.ret_prog == RET_LEN && bnd)
        begin
            r.ret_hit = 1'b1;
        end
        r.ret_prog = ret_next(s.ret_prog, u);
        return r;
    endfunction

    // verdict at the end byte
    function automatic logic match_rows(input match_t s, input logic in_text);
        logic r;
        r = s.kw_hit || s.ret_hit
            || (s.tok_pos == SELECT_LEN && s.sel_alive)
            || (s.tok_pos == WITH_LEN && s.with_alive)
            || (s.ret_prog == RET_LEN);
        return r && in_text;
    endfunction

endpackage

/* src/srsc_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srsc_front: leading blank and comment skipper
// Tracks the skip phase, drops blanks and comments, and pushes one request
// per text byte (with any held '-' or '/') and one per end byte.
// ----------------------------------------------------------------------------
module srsc_front
    import srsc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] text_byte,
    output logic       push,
    output req_t       req
);

    phase_t phase_reg;
    phase_t phase_next;
    logic   is_blank;

    assign is_blank = (text_byte == CH_SPACE) || (text_byte == CH_TAB)
        || (text_byte == CH_LF) || (text_byte == CH_CR);

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (text_byte == CH_NUL)
        begin
            phase_next = PH_BLANK;
        end
        else
        begin
            case (phase_reg)
                PH_BLANK:
                begin
                    if (text_byte == CH_DASH)
                        phase_next = PH_DASH;
                    else if (text_byte == CH_SLASH)
                        phase_next = PH_SLASH;
                    else if (!is_blank)
                        phase_next = PH_TEXT;
                end
                PH_DASH:  phase_next = (text_byte == CH_DASH) ? PH_LINE : PH_TEXT;
                PH_SLASH: phase_next = (text_byte == CH_STAR) ? PH_BLOCK : PH_TEXT;
                PH_LINE:
                begin
                    if (text_byte == CH_LF)
                        phase_next = PH_BLANK;
                end
                PH_BLOCK:
                begin
                    if (text_byte == CH_STAR)
                        phase_next = PH_BSTAR;
                end
                PH_BSTAR:
                begin
                    if (text_byte == CH_SLASH)
                        phase_next = PH_BLANK;
                    else if (text_byte != CH_STAR)
                        phase_next = PH_BLOCK;
                end
                PH_TEXT:  phase_next = PH_TEXT;
                default:  phase_next = PH_BLANK;
            endcase
        end
    end

    // request build
    always_comb
    begin
        push         = 1'b0;
        req.is_end   = 1'b0;
        req.in_text  = (phase_reg == PH_TEXT);
        req.has_pre  = 1'b0;
        req.pre_byte = (phase_reg == PH_SLASH) ? CH_SLASH : CH_DASH;
        req.body     = text_byte;
        if (text_byte == CH_NUL)
        begin
            push       = accept;
            req.is_end = 1'b1;
        end
        else
        begin
            case (phase_reg)
                PH_BLANK:
                begin
                    push = accept && !is_blank && (text_byte != CH_DASH)
                        && (text_byte != CH_SLASH);
                end
                PH_DASH:
                begin
                    push        = accept && (text_byte != CH_DASH);
                    req.has_pre = 1'b1;
                end
                PH_SLASH:
                begin
                    push        = accept && (text_byte != CH_STAR);
                    req.has_pre = 1'b1;
                end
                PH_TEXT:  push = accept;
                default:  push = 1'b0;
            endcase
        end
    end

    // phase register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            phase_reg <= PH_BLANK;
        else if (accept)
            phase_reg <= phase_next;
    end

endmodule

/* src/srsc_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srsc_queue: request queue between front and back
// Small register queue; lets the front keep taking bytes while the back
// waits on the result consumer.
// ----------------------------------------------------------------------------
module srsc_queue
    import srsc_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  req_t   push_req,
    input  logic   pop,
    output req_t   head_req,
    output qstat_t stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST  = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULLC = CNT_W'(DEPTH);

    req_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign stat.full  = (count_reg == FULLC);
    assign stat.empty = (count_reg == '0);
    assign head_req   = slot_reg[rd_ptr_reg];

    // occupancy
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_req;
    end

    // pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
            count_reg <= count_next;
        end
    end

endmodule

/* src/srsc_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srsc_back: keyword matcher and result register
// Runs SELECT / WITH / RETURNING matching on queued text bytes and loads
// the verdict into the output register on each end request.
// ----------------------------------------------------------------------------
module srsc_back
    import srsc_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  req_t   head_req,
    input  qstat_t stat,
    output logic   pop,
    output logic   out_valid,
    input  logic   out_ready,
    output logic   yields_rows
);

    match_t match_reg;
    match_t match_next;
    match_t after_pre;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   rows_reg;
    logic   slot_free;

    assign slot_free = !out_valid_reg || out_ready;
    assign pop       = !stat.empty && (!head_req.is_end || slot_free);

    // text step, held prefix byte first
    always_comb
    begin
        after_pre  = head_req.has_pre ? match_step(match_reg, head_req.pre_byte)
                                      : match_reg;
        match_next = match_reg;
        if (pop)
        begin
            if (head_req.is_end)
                match_next = MATCH_RESET;
            else
                match_next = match_step(after_pre, head_req.body);
        end
    end

    // output handshake
    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        if (pop && head_req.is_end)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg     <= MATCH_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            match_reg     <= match_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // verdict register
    always_ff @(posedge clk)
    begin
        if (pop && head_req.is_end)
            rows_reg <= match_rows(match_reg, head_req.in_text);
    end

    assign out_valid   = out_valid_reg;
    assign yields_rows = rows_reg;

endmodule

/* src/sql_result_set_classifier_top.sv */
`timescale 1ns / 1ps
// result path: an accepted end byte is queued, then its verdict is loaded into the output register
// throughput: one byte per cycle while the queue has room; match steps are combinational
// back pressure on the result side fills the request queue, then drops in_ready
// reset: rst_n is asynchronous, active low; it empties the queue and returns both
// the skip phase and the keyword match state to the start of a statement
// ----------------------------------------------------------------------------
// sql_result_set_classifier_top: SQL statement result set classifier
// Front skips leading blanks and comments, back matches the keywords and
// gives one bit per statement; a request queue decouples the two.
// ----------------------------------------------------------------------------
module sql_result_set_classifier_top
    import srsc_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] text_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       yields_rows
);

    logic   accept;
    logic   push;
    logic   pop;
    req_t   push_req;
    req_t   head_req;
    qstat_t stat;

    // input side takes a byte whenever the queue has room
    assign in_ready = !stat.full;
    assign accept   = in_valid && in_ready;

    srsc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .text_byte (text_byte),
        .push      (push),
        .req       (push_req)
    );

    srsc_queue #(
        .DEPTH (DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_req (push_req),
        .pop      (pop),
        .head_req (head_req),
        .stat     (stat)
    );

    srsc_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_req    (head_req),
        .stat        (stat),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .yields_rows (yields_rows)
    );

`ifndef NO_ASSERTIONS
    // an accepted end byte is always queued
    a_end_queued: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && text_byte == CH_NUL) |=> !stat.empty)
        else $error("end byte not queued");

    // a result appears only from an end request leaving the queue
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(pop && head_req.is_end))
        else $error("result without end request");

    // queue never both full and empty
    a_queue_status: assert property (@(posedge clk) disable iff (!rst_n)
        !(stat.full && stat.empty))
        else $error("queue status inconsistent");
`endif

endmodule

/* tb/tb_sql_result_set_classifier_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sql_result_set_classifier_top: result set classifier testbench
// Streams SQL statement bytes into the classifier with random gaps on both
// handshakes. A scoreboard class tracks the comment skip and keyword scan,
// then checks each yields_rows verdict in order against its own prediction.
// ----------------------------------------------------------------------------
module tb_sql_result_set_classifier_top
    import srsc_pkg::*;
();

    localparam int CLK_PERIOD   = 10;
    localparam int RANDOM_BYTES = 650;
    localparam int CYCLE_LIMIT  = 200000;

    // verdict predictor and ordered store of expected verdicts
    class rows_scoreboard;
        phase_t     phase;
        logic [2:0] tok_pos;
        bit         sel_live;
        bit         with_live;
        bit         kw_found;
        logic [3:0] ret_len;
        bit         ret_found;
        bit         expected_rows[$];
        int         errors;
        string      sel_word = "SELECT";
        string      with_word = "WITH";
        string      ret_word = "RETURNING";

        function new();
            errors = 0;
            restart();
        endfunction

        function void restart();
            phase     = PH_BLANK;
            tok_pos   = 3'd0;
            sel_live  = 1'b1;
            with_live = 1'b1;
            kw_found  = 1'b0;
            ret_len   = 4'd0;
            ret_found = 1'b0;
        endfunction

        function logic [7:0] to_upper(logic [7:0] c);
            if (c >= "a" && c <= "z")
            begin
                return c - 8'd32;
            end
            return c;
        endfunction

        function bit is_word_char(logic [7:0] c);
            return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z")
                || (c >= "0" && c <= "9") || (c == CH_UNDER);
        endfunction

        // longest prefix of the keyword that ends the matched text plus u
        function logic [3:0] advance_returning(logic [3:0] k, logic [7:0] u);
            logic [7:0] seen [10];
            int         n;
            int         j;
            int         i;
            bit         ok;
            if (k > 4'd9)
            begin
                k = 4'd0;
            end
            for (i = 0; i < k; i++)
            begin
                seen[i] = ret_word[i];
            end
            seen[k] = u;
            n = k + 1;
            for (j = (n < 9) ? n : 9; j > 0; j--)
            begin
                ok = 1'b1;
                for (i = 0; i < j; i++)
                begin
                    if (seen[n - j + i] != ret_word[i])
                    begin
                        ok = 1'b0;
                    end
                end
                if (ok)
                begin
                    return j[3:0];
                end
            end
            return 4'd0;
        endfunction

        // one byte of statement text through the keyword scan
        function void scan_text(logic [7:0] c);
            logic [7:0] u;
            u = to_upper(c);
            if (tok_pos < 3'd6)
            begin
                sel_live = sel_live && (u == sel_word[tok_pos]);
            end
            else if (tok_pos == 3'd6)
            begin
                if (sel_live && !is_word_char(c))
                begin
                    kw_found = 1'b1;
                end
                sel_live = 1'b0;
            end
            if (tok_pos < 3'd4)
            begin
                with_live = with_live && (u == with_word[tok_pos]);
            end
            else if (tok_pos == 3'd4)
            begin
                if (with_live && !is_word_char(c))
                begin
                    kw_found = 1'b1;
                end
                with_live = 1'b0;
            end
            if (tok_pos < 3'd7)
            begin
                tok_pos = tok_pos + 3'd1;
            end
            if (ret_len == 4'd9 && !is_word_char(c))
            begin
                ret_found = 1'b1;
            end
            ret_len = advance_returning(ret_len, u);
        endfunction

        // accepted input request
        function void note_byte(logic [7:0] c);
            bit rows;
            if (c == CH_NUL)
            begin
                rows = 1'b0;
                if (phase == PH_TEXT)
                begin
                    rows = kw_found || ret_found || ret_len == 4'd9
                        || (tok_pos == 3'd6 && sel_live)
                        || (tok_pos == 3'd4 && with_live);
                end
                expected_rows.push_back(rows);
                restart();
                return;
            end
            case (phase)
                PH_BLANK:
                begin
                    if (c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR)
                    begin
                        phase = PH_BLANK;
                    end
                    else if (c == CH_DASH)
                    begin
                        phase = PH_DASH;
                    end
                    else if (c == CH_SLASH)
                    begin
                        phase = PH_SLASH;
                    end
                    else
                    begin
                        phase = PH_TEXT;
                        scan_text(c);
                    end
                end
                PH_DASH:
                begin
                    if (c == CH_DASH)
                    begin
                        phase = PH_LINE;
                    end
                    else
                    begin
                        phase = PH_TEXT;
                        scan_text(CH_DASH);
                        scan_text(c);
                    end
                end
                PH_SLASH:
                begin
                    if (c == CH_STAR)
                    begin
                        phase = PH_BLOCK;
                    end
                    else
                    begin
                        phase = PH_TEXT;
                        scan_text(CH_SLASH);
                        scan_text(c);
                    end
                end
                PH_LINE:
                begin
                    if (c == CH_LF)
                    begin
                        phase = PH_BLANK;
                    end
                end
                PH_BLOCK:
                begin
                    if (c == CH_STAR)
                    begin
                        phase = PH_BSTAR;
                    end
                end
                PH_BSTAR:
                begin
                    if (c == CH_SLASH)
                    begin
                        phase = PH_BLANK;
                    end
                    else if (c != CH_STAR)
                    begin
                        phase = PH_BLOCK;
                    end
                end
                PH_TEXT:
                begin
                    scan_text(c);
                end
                default:
                begin
                    phase = PH_BLANK;
                end
            endcase
        endfunction

        task report(string what);
            $display("ERROR at %0t: %s", $realtime, what);
            errors++;
        endtask

        // accepted result request against the oldest expectation
        task check_rows(logic got);
            logic want;
            if (expected_rows.size() == 0)
            begin
                report($sformatf("result yields_rows=%b with none expected", got));
                return;
            end
            want = expected_rows.pop_front();
            if (got !== want)
            begin
                report($sformatf("yields_rows got %b want %b", got, want));
            end
        endtask

        task check_leftover();
            if (expected_rows.size() != 0)
            begin
                report($sformatf("%0d results never arrived", expected_rows.size()));
            end
        endtask

        function int pending();
            return expected_rows.size();
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] text_byte;
    logic       out_valid;
    logic       out_ready;
    logic       yields_rows;

    rows_scoreboard sb = new();
    logic [7:0]     stream[$];
    bit             send_calm;
    bit             recv_calm;
    int             cycles;

    sql_result_set_classifier_top uut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .text_byte   (text_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .yields_rows (yields_rows)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #(CLK_PERIOD / 2) clk = ~clk;
        end
    end

    // run limit
    initial
    begin
        cycles = 0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("sql_result_set_classifier_top: mismatch");
            $finish;
        end
    end

    // gap draw with occasional stretches of no idling
    function automatic int draw_wait(inout bit calm);
        if ($urandom_range(0, 39) == 0)
        begin
            calm = !calm;
        end
        return calm ? 0 : $urandom_range(0, 11);
    endfunction

    function automatic logic [7:0] mix_case(logic [7:0] c);
        if (c >= "A" && c <= "Z" && $urandom_range(0, 1) == 1)
        begin
            return c + 8'd32;
        end
        return c;
    endfunction

    task automatic add_text(string s);
        for (int i = 0; i < s.len(); i++)
        begin
            stream.push_back(mix_case(s[i]));
        end
    endtask

    // random nonzero bytes, optionally avoiding one value
    task automatic add_junk(int count, logic [7:0] avoid);
        logic [7:0] b;
        for (int i = 0; i < count; i++)
        begin
            b = 8'($urandom_range(1, 255));
            if (b == avoid)
            begin
                b = "x";
            end
            stream.push_back(b);
        end
    endtask

    task automatic add_word(int count);
        string letters;
        letters = "ABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_";
        for (int i = 0; i < count; i++)
        begin
            stream.push_back(mix_case(letters[$urandom_range(0, letters.len() - 1)]));
        end
    endtask

    function automatic string odd_first_token();
        case ($urandom_range(0, 5))
            0: return "SELECTED";
            1: return "SELEC";
            2: return "WIT";
            3: return "WITHIN";
            4: return "WITH_";
            default: return "SELECT9";
        endcase
    endfunction

    function automatic string body_token();
        case ($urandom_range(0, 6))
            0: return "RETURNING";
            1: return "RETURRETURNING";
            2: return "RETURNIN";
            3: return "XRETURNING";
            4: return "RETURNING_";
            5: return "RRETURNING";
            default: return "SELECT";
        endcase
    endfunction

    task automatic add_separator();
        case ($urandom_range(0, 5))
            0: stream.push_back(CH_SPACE);
            1: stream.push_back("(");
            2: stream.push_back(",");
            3: stream.push_back(8'($urandom_range(128, 255)));
            4: stream.push_back(CH_UNDER);
            default: add_word(1);
        endcase
    endtask

    // one random statement, well formed most of the time
    task automatic add_statement();
        int pieces;
        int kind;
        pieces = $urandom_range(0, 2);
        for (int i = 0; i < pieces; i++)
        begin
            case ($urandom_range(0, 3))
                0:
                begin
                    case ($urandom_range(0, 3))
                        0: stream.push_back(CH_SPACE);
                        1: stream.push_back(CH_TAB);
                        2: stream.push_back(CH_CR);
                        default: stream.push_back(CH_LF);
                    endcase
                end
                1:
                begin
                    add_text("--");
                    add_junk($urandom_range(0, 4), CH_LF);
                    stream.push_back(CH_LF);
                end
                2:
                begin
                    add_text("/*");
                    add_junk($urandom_range(0, 4), CH_STAR);
                    add_text("*/");
                end
                default:
                begin
                    add_text("/***/");
                end
            endcase
        end
        kind = $urandom_range(0, 11);
        case (kind)
            0, 1, 2: add_text("SELECT");
            3, 4: add_text("WITH");
            5: add_text("RETURNING");
            6: add_text(odd_first_token());
            7: add_word($urandom_range(1, 9));
            8:
            begin
                stream.push_back($urandom_range(0, 1) ? CH_DASH : CH_SLASH);
                add_word($urandom_range(1, 4));
            end
            9: add_junk($urandom_range(1, 6), CH_NUL);
            10:
            begin
                // statement ends inside a comment
                add_text($urandom_range(0, 1) ? "/*" : "--");
                add_junk($urandom_range(0, 3), CH_NUL);
            end
            default:
            begin
            end
        endcase
        if (kind < 10 && $urandom_range(0, 3) != 0)
        begin
            pieces = $urandom_range(1, 4);
            for (int i = 0; i < pieces; i++)
            begin
                add_separator();
                case ($urandom_range(0, 3))
                    0, 1: add_text(body_token());
                    2: add_word($urandom_range(1, 6));
                    default: add_junk($urandom_range(1, 4), CH_NUL);
                endcase
            end
            if ($urandom_range(0, 1) == 1)
            begin
                add_separator();
            end
        end
        stream.push_back(CH_NUL);
    endtask

    task automatic load_directed();
        // blank then lone dash
        add_text(" -x");
        stream.push_back(CH_NUL);
        // slash star slash leaves the comment open
        add_text("/*/");
        stream.push_back(CH_NUL);
        add_text("wItH");
        stream.push_back(CH_NUL);
        // high bytes around a trailing keyword
        stream.push_back(8'hFF);
        add_text("RETURNING");
        stream.push_back(8'h80);
        stream.push_back(CH_NUL);
        // empty statement
        stream.push_back(CH_NUL);
    endtask

    // one input request, starts and ends at a falling edge
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = draw_wait(send_calm);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  <= 1'b1;
        text_byte <= b;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        sb.note_byte(b);
        @(negedge clk);
    endtask

    task automatic send_stream();
        while (stream.size() > 0)
        begin
            send_byte(stream.pop_front());
        end
        in_valid <= 1'b0;
    endtask

    // result side: random stalls per request
    initial
    begin
        int gap;
        out_ready = 1'b0;
        recv_calm = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            gap = draw_wait(recv_calm);
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
            begin
                @(posedge clk);
            end
            @(negedge clk);
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            sb.check_rows(yields_rows);
        end
    end

    // stimulus
    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        text_byte = 8'h00;
        send_calm = 1'b0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        load_directed();
        send_stream();

        // hold the sender until every verdict is back
        while (sb.pending() != 0)
        begin
            @(negedge clk);
        end
        repeat (4) @(negedge clk);

        while (stream.size() < RANDOM_BYTES)
        begin
            add_statement();
        end
        send_stream();

        // drain, then allow the output latency
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (10) @(posedge clk);
        sb.check_leftover();
        if (sb.errors == 0)
        begin
            $display("sql_result_set_classifier_top: match");
        end
        else
        begin
            $display("sql_result_set_classifier_top: mismatch");
        end
        $finish;
    end

endmodule

/* sql_result_set_classifier_top.f */
src/srsc_pkg.sv
src/srsc_front.sv
src/srsc_queue.sv
src/srsc_back.sv
src/sql_result_set_classifier_top.sv
tb/tb_sql_result_set_classifier_top.sv
